// ===== rtl/decimating_iq_adc_quantizer_defines.svh =====
// assertion macros used by the checker file
`ifndef DECIMATING_IQ_ADC_QUANTIZER_DEFINES_SVH
`define DECIMATING_IQ_ADC_QUANTIZER_DEFINES_SVH

// property checked on every edge outside reset
`define DIQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("diq check failed");

// property checked on every edge, reset included
`define DIQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("diq check failed during or after reset");

`endif

// ===== rtl/diq_pkg.sv =====
package diq_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH    = 24;
    localparam int MAX_CODE_BITS   = 16;
    localparam int CODE_WIDTH      = 17;
    localparam int BITS_WIDTH      = 5;
    localparam int VREF_WIDTH      = 23;
    localparam int CPV_WIDTH       = 32;
    localparam int COUNT_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int PROD_WIDTH      = 56;
    localparam int IDX_SHIFT       = 36;

    // register reset values
    localparam logic [BITS_WIDTH-1:0]  CODE_BITS_RST = 5'd12;
    localparam logic [VREF_WIDTH-1:0]  VREF_RST      = 23'h10_0000;
    localparam logic [CPV_WIDTH-1:0]   CPV_RST       = 32'h0800_0000;
    localparam logic [COUNT_WIDTH-1:0] DECIM_RST     = 16'd1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CODE_BITS      = 3'd0,
        REG_REFERENCE      = 3'd1,
        REG_CODES_PER_VOLT = 3'd2,
        REG_TWOS_COMP      = 3'd3,
        REG_DECIMATION     = 3'd4,
        REG_CAPTURE_OFFSET = 3'd5,
        REG_INIT_CODE_I    = 3'd6,
        REG_INIT_CODE_Q    = 3'd7
    } reg_index_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_IDX,
        ST_MUL_LVL,
        ST_FINISH,
        ST_POST
    } state_t;

    // shared multiplier operation
    typedef enum logic [1:0] {
        OP_NONE,
        OP_IDX,
        OP_LVL
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        mul_op_t op;
        logic    rail_q;
        logic    finish;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic convert;
    } dp_status_t;

endpackage

// ===== rtl/diq_sample_if.sv =====
interface diq_sample_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0]    sample_i;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0]    sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

// ===== rtl/diq_result_if.sv =====
interface diq_result_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [diq_pkg::CODE_WIDTH-1:0]      code_i;
    logic signed [diq_pkg::CODE_WIDTH-1:0]      code_q;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0]    level_i;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0]    level_q;
    logic                                       converted;

    modport source (output valid, output code_i, output code_q, output level_i,
                    output level_q, output converted, input ready);
    modport sink (input valid, input code_i, input code_q, input level_i,
                  input level_q, input converted, output ready);
endinterface

// ===== rtl/diq_cfg_if.sv =====
interface diq_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [diq_pkg::CFG_INDEX_WIDTH-1:0]    index;
    logic [diq_pkg::CFG_DATA_WIDTH-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/diq_datapath.sv =====
module diq_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  diq_pkg::dp_cmd_t                        cmd,
    output diq_pkg::dp_status_t                     status,
    input  logic                                    cfg_we,
    input  logic [diq_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [diq_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic signed [diq_pkg::SAMPLE_WIDTH-1:0] sample_i,
    input  logic signed [diq_pkg::SAMPLE_WIDTH-1:0] sample_q,
    output logic signed [diq_pkg::CODE_WIDTH-1:0]   code_i,
    output logic signed [diq_pkg::CODE_WIDTH-1:0]   code_q,
    output logic signed [diq_pkg::SAMPLE_WIDTH-1:0] level_i,
    output logic signed [diq_pkg::SAMPLE_WIDTH-1:0] level_q,
    output logic                                    converted
);

    // configuration registers
    logic [diq_pkg::BITS_WIDTH-1:0]   code_bits_reg;
    logic [diq_pkg::VREF_WIDTH-1:0]   vref_reg;
    logic [diq_pkg::CPV_WIDTH-1:0]    cpv_reg;
    logic                             twos_reg;
    logic [diq_pkg::COUNT_WIDTH-1:0]  decim_reg;
    logic [diq_pkg::COUNT_WIDTH-1:0]  offset_reg;

    // item state
    logic [diq_pkg::COUNT_WIDTH-1:0]         window_count_reg;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] captured_i_reg;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] captured_q_reg;
    logic signed [diq_pkg::CODE_WIDTH-1:0]   held_code_i_reg;
    logic signed [diq_pkg::CODE_WIDTH-1:0]   held_code_q_reg;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] held_level_i_reg;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] held_level_q_reg;
    logic                                    any_conv_reg;
    logic                                    conv_reg;

    // arithmetic registers
    logic [diq_pkg::PROD_WIDTH-1:0]      prod_reg;
    logic [diq_pkg::MAX_CODE_BITS-1:0]   idx_reg;

    // output register payload
    logic signed [diq_pkg::CODE_WIDTH-1:0]   out_code_i_reg;
    logic signed [diq_pkg::CODE_WIDTH-1:0]   out_code_q_reg;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] out_level_i_reg;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] out_level_q_reg;
    logic                                    out_conv_reg;

    logic [diq_pkg::BITS_WIDTH-1:0]          bits_c;
    logic [diq_pkg::COUNT_WIDTH-1:0]         factor_c;
    logic [diq_pkg::COUNT_WIDTH-1:0]         phase_c;
    logic [diq_pkg::COUNT_WIDTH-1:0]         wc_inc_c;
    logic signed [diq_pkg::SAMPLE_WIDTH-1:0] x_c;
    logic signed [diq_pkg::SAMPLE_WIDTH:0]   x_ext_c;
    logic signed [diq_pkg::SAMPLE_WIDTH:0]   vref_s_c;
    logic signed [diq_pkg::SAMPLE_WIDTH:0]   nvref_s_c;
    logic signed [diq_pkg::SAMPLE_WIDTH:0]   x_clamp_c;
    logic signed [diq_pkg::SAMPLE_WIDTH:0]   x_shift_c;
    logic [diq_pkg::SAMPLE_WIDTH-1:0]        mul_a_c;
    logic [diq_pkg::CPV_WIDTH-1:0]           mul_b_c;
    logic [diq_pkg::PROD_WIDTH-1:0]          product_c;
    logic [19:0]                             idx_raw_c;
    logic [diq_pkg::CODE_WIDTH-1:0]          levels_m1_c;
    logic [diq_pkg::CODE_WIDTH-1:0]          half_c;
    logic [diq_pkg::MAX_CODE_BITS-1:0]       idx_sat_c;
    logic [diq_pkg::CODE_WIDTH-1:0]          odd_c;
    logic [40:0]                             num_round_c;
    logic [40:0]                             num_shift_c;
    logic signed [diq_pkg::SAMPLE_WIDTH:0]   level_c;
    logic [diq_pkg::CODE_WIDTH-1:0]          code_c;
    logic signed [diq_pkg::CODE_WIDTH-1:0]   init_code_c;

    // effective resolution, window length and capture phase
    always_comb
    begin
        if (code_bits_reg == 5'd0)
            bits_c = 5'd1;
        else if (code_bits_reg > 5'(diq_pkg::MAX_CODE_BITS))
            bits_c = 5'(diq_pkg::MAX_CODE_BITS);
        else
            bits_c = code_bits_reg;
        factor_c = (decim_reg == 16'd0) ? 16'd1 : decim_reg;
        phase_c  = (offset_reg < factor_c) ? offset_reg : factor_c - 16'd1;
        wc_inc_c = window_count_reg + 16'd1;
    end

    assign status.convert = (wc_inc_c >= factor_c);

    // rail clamp and shift to the unsigned range
    always_comb
    begin
        x_c       = cmd.rail_q ? captured_q_reg : captured_i_reg;
        x_ext_c   = {x_c[diq_pkg::SAMPLE_WIDTH-1], x_c};
        vref_s_c  = $signed({2'b00, vref_reg});
        nvref_s_c = -vref_s_c;
        if (x_ext_c < nvref_s_c)
            x_clamp_c = nvref_s_c;
        else if (x_ext_c > vref_s_c)
            x_clamp_c = vref_s_c;
        else
            x_clamp_c = x_ext_c;
        x_shift_c = x_clamp_c + vref_s_c;
    end

    // index saturation from the registered product
    always_comb
    begin
        idx_raw_c   = prod_reg[diq_pkg::IDX_SHIFT+19:diq_pkg::IDX_SHIFT];
        levels_m1_c = (17'd1 << bits_c) - 17'd1;
        half_c      = 17'd1 << (bits_c - 5'd1);
        if ({3'b000, levels_m1_c} < idx_raw_c)
            idx_sat_c = levels_m1_c[diq_pkg::MAX_CODE_BITS-1:0];
        else
            idx_sat_c = idx_raw_c[diq_pkg::MAX_CODE_BITS-1:0];
        odd_c = {idx_sat_c, 1'b1};
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.op)
            diq_pkg::OP_IDX:
            begin
                mul_a_c = x_shift_c[diq_pkg::SAMPLE_WIDTH-1:0];
                mul_b_c = cpv_reg;
            end
            diq_pkg::OP_LVL:
            begin
                mul_a_c = {7'd0, odd_c};
                mul_b_c = {9'd0, vref_reg};
            end
            default:
            begin
                mul_a_c = '0;
                mul_b_c = '0;
            end
        endcase
        product_c = 56'(mul_a_c) * 56'(mul_b_c);
    end

    // level rounding and code format
    always_comb
    begin
        num_round_c = {1'b0, prod_reg[39:0]} + {24'd0, half_c};
        num_shift_c = num_round_c >> bits_c;
        level_c     = $signed({1'b0, num_shift_c[diq_pkg::SAMPLE_WIDTH-1:0]}) - vref_s_c;
        code_c      = {1'b0, idx_reg} - (twos_reg ? half_c : 17'd0);
        init_code_c = $signed(cfg_data[diq_pkg::CODE_WIDTH-1:0]);
    end

    // configuration, window and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_bits_reg    <= diq_pkg::CODE_BITS_RST;
            vref_reg         <= diq_pkg::VREF_RST;
            cpv_reg          <= diq_pkg::CPV_RST;
            twos_reg         <= 1'b0;
            decim_reg        <= diq_pkg::DECIM_RST;
            offset_reg       <= '0;
            window_count_reg <= '0;
            captured_i_reg   <= '0;
            captured_q_reg   <= '0;
            held_code_i_reg  <= '0;
            held_code_q_reg  <= '0;
            held_level_i_reg <= '0;
            held_level_q_reg <= '0;
            any_conv_reg     <= 1'b0;
            conv_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (diq_pkg::reg_index_t'(cfg_index))
                    diq_pkg::REG_CODE_BITS:
                        code_bits_reg <= cfg_data[diq_pkg::BITS_WIDTH-1:0];
                    diq_pkg::REG_REFERENCE:
                        vref_reg <= cfg_data[diq_pkg::VREF_WIDTH-1:0];
                    diq_pkg::REG_CODES_PER_VOLT:
                        cpv_reg <= cfg_data;
                    diq_pkg::REG_TWOS_COMP:
                        twos_reg <= cfg_data[0];
                    diq_pkg::REG_DECIMATION:
                        decim_reg <= cfg_data[diq_pkg::COUNT_WIDTH-1:0];
                    diq_pkg::REG_CAPTURE_OFFSET:
                        offset_reg <= cfg_data[diq_pkg::COUNT_WIDTH-1:0];
                    diq_pkg::REG_INIT_CODE_I:
                        if (!any_conv_reg)
                            held_code_i_reg <= init_code_c;
                    diq_pkg::REG_INIT_CODE_Q:
                        if (!any_conv_reg)
                            held_code_q_reg <= init_code_c;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept)
            begin
                if (window_count_reg == phase_c)
                begin
                    captured_i_reg <= sample_i;
                    captured_q_reg <= sample_q;
                end
                window_count_reg <= status.convert ? 16'd0 : wc_inc_c;
                conv_reg         <= status.convert;
            end
            if (cmd.finish)
            begin
                any_conv_reg <= 1'b1;
                if (cmd.rail_q)
                begin
                    held_code_q_reg  <= $signed(code_c);
                    held_level_q_reg <= level_c[diq_pkg::SAMPLE_WIDTH-1:0];
                end
                else
                begin
                    held_code_i_reg  <= $signed(code_c);
                    held_level_i_reg <= level_c[diq_pkg::SAMPLE_WIDTH-1:0];
                end
            end
        end
    end

    // multiplier product and index registers
    always_ff @(posedge clk)
    begin
        if (cmd.op != diq_pkg::OP_NONE)
            prod_reg <= product_c;
        if (cmd.op == diq_pkg::OP_LVL)
            idx_reg <= idx_sat_c;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_code_i_reg  <= held_code_i_reg;
            out_code_q_reg  <= held_code_q_reg;
            out_level_i_reg <= held_level_i_reg;
            out_level_q_reg <= held_level_q_reg;
            out_conv_reg    <= conv_reg;
        end
    end

    assign code_i    = out_code_i_reg;
    assign code_q    = out_code_q_reg;
    assign level_i   = out_level_i_reg;
    assign level_q   = out_level_q_reg;
    assign converted = out_conv_reg;

endmodule

// ===== rtl/diq_controller.sv =====
module diq_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  diq_pkg::dp_status_t status,
    output diq_pkg::dp_cmd_t    cmd
);

    diq_pkg::state_t state_reg;
    diq_pkg::state_t state_next;
    logic            rail_reg;
    logic            rail_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        rail_next  = rail_reg;
        case (state_reg)
            diq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rail_next  = 1'b0;
                    state_next = status.convert ? diq_pkg::ST_MUL_IDX : diq_pkg::ST_POST;
                end
            end
            diq_pkg::ST_MUL_IDX:
                state_next = diq_pkg::ST_MUL_LVL;
            diq_pkg::ST_MUL_LVL:
                state_next = diq_pkg::ST_FINISH;
            diq_pkg::ST_FINISH:
            begin
                if (rail_reg)
                    state_next = diq_pkg::ST_POST;
                else
                begin
                    rail_next  = 1'b1;
                    state_next = diq_pkg::ST_MUL_IDX;
                end
            end
            diq_pkg::ST_POST:
            begin
                if (out_free)
                    state_next = diq_pkg::ST_IDLE;
            end
            default:
                state_next = diq_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.op       = diq_pkg::OP_NONE;
        cmd.rail_q   = rail_reg;
        cmd.finish   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            diq_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            diq_pkg::ST_MUL_IDX:
                cmd.op = diq_pkg::OP_IDX;
            diq_pkg::ST_MUL_LVL:
                cmd.op = diq_pkg::OP_LVL;
            diq_pkg::ST_FINISH:
                cmd.finish = 1'b1;
            diq_pkg::ST_POST:
                cmd.load_out = out_free;
            default:
            begin
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= diq_pkg::ST_IDLE;
            rail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rail_reg      <= rail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/decimating_iq_adc_quantizer.sv =====
// Decimating I/Q quantizer: one sample beat in, one result beat out for every
// sample. A sample that does not end a decimation window goes from IDLE to
// POST; one that ends a window runs MUL_IDX, MUL_LVL and FINISH for I, then Q,
// as the single shared 24x32 multiplier is used four times in turn (index and
// rebuilt level, I then Q). A finished result sits in the output register
// while the next sample beat is taken. Configuration writes are accepted in
// every cycle and must be issued only while no sample is in flight.
module decimating_iq_adc_quantizer (
    input  logic                clk,
    input  logic                rst_n,
    diq_sample_if.sink          samples,
    diq_result_if.source        results,
    diq_cfg_if.sink             cfg
);

    diq_pkg::dp_cmd_t    cmd;
    diq_pkg::dp_status_t status;

    // configuration channel never stalls
    assign cfg.ready = 1'b1;

    diq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    diq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sample_i  (samples.sample_i),
        .sample_q  (samples.sample_q),
        .code_i    (results.code_i),
        .code_q    (results.code_q),
        .level_i   (results.level_i),
        .level_q   (results.level_q),
        .converted (results.converted)
    );

endmodule

// ===== rtl/diq_checker.sv =====
`include "decimating_iq_adc_quantizer_defines.svh"

module diq_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [diq_pkg::CODE_WIDTH-1:0]   out_code_i,
    input logic signed [diq_pkg::SAMPLE_WIDTH-1:0] out_level_q
);

    // stalled result beat stays valid
    `DIQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

    // stalled result payload holds (I code and Q level checked)
    `DIQ_ASSERT(a_out_stable, clk, rst_n,
        out_valid && !out_ready |=> $stable(out_code_i) && $stable(out_level_q))

    // one sample at a time: no beat taken right after another
    `DIQ_ASSERT(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready)

    // no result beat shown while in reset
    `DIQ_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid)

endmodule

bind decimating_iq_adc_quantizer diq_checker u_diq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_code_i  (results.code_i),
    .out_level_q (results.level_q)
);
